/* hdl/gem_pkg.sv */
// Shared constants and the gradient struct type for the gradient edge magnitude block.
// No dependencies.
package gem_pkg;
    localparam int MaxWidthDefault  = 1024;
    localparam int MaxHeightDefault = 1024;
    localparam logic [10:0] ResetWidth  = 11'd640;
    localparam logic [10:0] ResetHeight = 11'd480;

    localparam logic [1:0] OpSobel   = 2'd0;
    localparam logic [1:0] OpPrewitt = 2'd1;
    localparam logic [1:0] OpScharr  = 2'd2;
    localparam logic [1:0] OpRoberts = 2'd3;

    localparam logic [1:0] RegWidth  = 2'd0;
    localparam logic [1:0] RegHeight = 2'd1;
    localparam logic [1:0] RegOp     = 2'd2;

    // Result of the window stage handed to the magnitude stage.
    typedef struct packed {
        logic        valid;
        logic        last;
        logic [1:0]  op;
        logic [13:0] gx;
        logic [13:0] gy;
    } t_grad;
endpackage

/* hdl/gradient_edge_magnitude.sv */
// Gradient edge magnitude. A pixel beat passes the line stores (read, then write),
// then the squares and the bit-serial root, before its result is valid.
// One beat at a time: a beat is taken only while the window is idle and the
// magnitude unit is free; a result waiting in the output register holds no input.
// Results trail the pixel stream by image_width+1 positions. Reset (synchronous,
// active low) restores 640x480 Sobel and clears the position and window.
module gradient_edge_magnitude #(
    parameter int MAX_WIDTH  = gem_pkg::MaxWidthDefault,
    parameter int MAX_HEIGHT = gem_pkg::MaxHeightDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_edge_value,
    output logic        o_frame_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    gem_pkg::t_grad w_grad;
    logic w_ready, w_busy;

    // Configuration is always taken; the frame restarts on geometry writes.
    assign o_cfg_ready = 1'b1;
    assign o_stall     = !w_ready;

    gem_window #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_window (
        .i_clk, .i_rst_n,
        .i_cfg_valid(i_cfg_valid), .i_cfg_index, .i_cfg_data,
        .i_start(i_valid && w_ready), .i_mode, .i_pixel,
        .o_ready(w_ready), .o_grad(w_grad), .i_sink_busy(w_busy || w_grad.valid)
    );

    gem_sqrt u_sqrt (
        .i_clk, .i_rst_n, .i_grad(w_grad), .o_busy(w_busy),
        .o_valid, .o_edge_value, .o_frame_end, .i_stall
    );

    // A new gradient only arrives while the magnitude unit is free.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_grad.valid |-> !w_busy)
        else $error("gradient overran magnitude unit");
    // A stalled result beat stays in place with its payload unchanged.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_edge_value) && $stable(o_frame_end)))
        else $error("stalled result beat changed");
endmodule

/* hdl/gem_sqrt.sv */
// Magnitude unit: squares, bit-serial floor square root, normalisation and clamp.
// Depends on gem_pkg.
module gem_sqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gem_pkg::t_grad    i_grad,
    output logic              o_busy,
    output logic              o_valid,
    output logic [7:0]        o_edge_value,
    output logic              o_frame_end,
    input  logic              i_stall
);
    typedef enum logic [1:0] {S_IDLE, S_SQ, S_ROOT} t_state;
    t_state      r_state;
    logic [27:0] r_sq_x, r_sq_y;
    logic [28:0] r_v;
    logic [28:0] r_res;
    logic [28:0] r_bit;
    logic [1:0]  r_op;
    logic        r_last;
    logic [7:0]  r_edge;
    logic        r_frame_end;
    logic        r_valid;
    logic [28:0] n_sum;
    logic [14:0] n_root;
    logic [14:0] n_div;
    logic [3:0]  n_rem3;
    logic [14:0] n_q3;
    logic        n_done;

    assign n_sum  = r_res + r_bit;
    assign n_root = r_res[14:0];
    // divide by 3 via reciprocal: q = (x*21846)>>16, corrected
    assign n_q3   = 15'((32'(n_root) * 32'd21846) >> 16);
    assign n_rem3 = 4'(n_root - 15'(n_q3 * 15'd3));

    always_comb begin
        case (r_op)
            gem_pkg::OpSobel:   n_div = n_root >> 2;
            gem_pkg::OpPrewitt: n_div = (n_rem3 >= 4'd3) ? n_q3 + 15'd1 : n_q3;
            gem_pkg::OpScharr:  n_div = n_root >> 4;
            default:            n_div = n_root;
        endcase
    end

    // The root holds its answer until the output register is free or being emptied.
    assign n_done       = (r_state == S_ROOT) && (r_bit == '0) && (!r_valid || !i_stall);
    assign o_busy       = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_edge_value = r_edge;
    assign o_frame_end  = r_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (n_done) r_valid <= 1'b1;
            else if (!i_stall) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_grad.valid) begin
                        r_sq_x  <= 28'($signed(i_grad.gx) * $signed(i_grad.gx));
                        r_sq_y  <= 28'($signed(i_grad.gy) * $signed(i_grad.gy));
                        r_op    <= i_grad.op;
                        r_last  <= i_grad.last;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_v     <= 29'(r_sq_x) + 29'(r_sq_y);
                    r_res   <= '0;
                    r_bit   <= 29'(1) << 28;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (r_bit == '0) begin
                        if (n_done) begin
                            r_edge      <= (n_div > 15'd255) ? 8'd255 : n_div[7:0];
                            r_frame_end <= r_last;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        if (r_v >= n_sum) begin
                            r_v   <= r_v - n_sum;
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* hdl/gem_window.sv */
// Line stores, 3x3 window and raster position control; produces gradients.
// Depends on gem_pkg.
module gem_window #(
    parameter int MAX_WIDTH  = gem_pkg::MaxWidthDefault,
    parameter int MAX_HEIGHT = gem_pkg::MaxHeightDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    input  logic [1:0]     i_cfg_index,
    input  logic [10:0]    i_cfg_data,
    input  logic           i_start,
    input  logic           i_mode,
    input  logic [7:0]     i_pixel,
    output logic           o_ready,
    output gem_pkg::t_grad o_grad,
    input  logic           i_sink_busy
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT + 2) + 1;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_WRITE} t_state;
    t_state r_state;

    logic [7:0]  r_upper [MAX_WIDTH];
    logic [7:0]  r_middle[MAX_WIDTH];
    logic [7:0]  r_up_q, r_mid_q;
    logic [10:0] r_width, r_height;
    logic [1:0]  r_op;
    logic [AW:0] r_col;
    logic [HW-1:0] r_row;
    logic [7:0]  r_win [9];
    logic [7:0]  r_px;
    logic [AW:0] r_c;

    logic [AW:0]   n_w;
    logic [HW-1:0] n_h;
    logic [AW:0]   n_c;
    logic          n_flush;
    logic [7:0]    n_in;
    logic [7:0]    n_t0, n_t1, n_t2;
    logic          n_emit, n_last, n_lfix, n_rfix;
    logic [7:0]    p[3][3];
    logic signed [13:0] n_gx, n_gy, n_a, n_b;

    always_comb begin
        if (r_width == 11'd0) n_w = (AW+1)'(1);
        else if (32'(r_width) > MAX_WIDTH) n_w = (AW+1)'(MAX_WIDTH);
        else n_w = (AW+1)'(r_width);
        if (r_height == 11'd0) n_h = HW'(1);
        else if (32'(r_height) > MAX_HEIGHT) n_h = HW'(MAX_HEIGHT);
        else n_h = HW'(r_height);
    end

    assign n_c     = (r_col >= n_w) ? '0 : r_col;
    assign n_flush = (r_row >= n_h);
    assign o_ready = (r_state == S_IDLE) && !i_sink_busy;

    // Read-modify-write in S_WRITE, using data read in S_READ.
    assign n_in = n_flush ? r_mid_q : r_px;
    always_comb begin
        if (r_row == '0) begin
            n_t0 = n_in; n_t1 = n_in; n_t2 = n_in;
        end else begin
            n_t0 = (r_row >= HW'(2)) ? r_up_q : r_mid_q;
            n_t1 = r_mid_q;
            n_t2 = n_in;
        end
    end
    assign n_emit = (r_row >= HW'(2)) || (r_row == HW'(1) && r_c >= (AW+1)'(1));
    assign n_last = (r_row == n_h + HW'(1)) && (r_c == '0);
    assign n_lfix = (r_c == (AW+1)'(1)) || (n_w == (AW+1)'(1));
    assign n_rfix = (r_c == '0);

    // Window after shift: column 1 = old col 2, column 2 = new triple (old col 2 at the right border).
    always_comb begin
        p[0][1] = r_win[2]; p[1][1] = r_win[5]; p[2][1] = r_win[8];
        p[0][0] = n_lfix ? r_win[2] : r_win[1];
        p[1][0] = n_lfix ? r_win[5] : r_win[4];
        p[2][0] = n_lfix ? r_win[8] : r_win[7];
        p[0][2] = n_rfix ? r_win[2] : n_t0;
        p[1][2] = n_rfix ? r_win[5] : n_t1;
        p[2][2] = n_rfix ? r_win[8] : n_t2;
        case (r_op)
            gem_pkg::OpScharr: begin n_a = 14'sd3; n_b = 14'sd10; end
            gem_pkg::OpSobel:  begin n_a = 14'sd1; n_b = 14'sd2;  end
            default:           begin n_a = 14'sd1; n_b = 14'sd1;  end
        endcase
        if (r_op == gem_pkg::OpRoberts) begin
            n_gx = $signed({6'd0, p[1][1]}) - $signed({6'd0, p[2][2]});
            n_gy = $signed({6'd0, p[2][1]}) - $signed({6'd0, p[1][2]});
        end else begin
            n_gx = 14'(n_a * ($signed({6'd0, p[0][2]}) - $signed({6'd0, p[0][0]}))
                 + n_b * ($signed({6'd0, p[1][2]}) - $signed({6'd0, p[1][0]}))
                 + n_a * ($signed({6'd0, p[2][2]}) - $signed({6'd0, p[2][0]})));
            n_gy = 14'(n_a * ($signed({6'd0, p[2][0]}) - $signed({6'd0, p[0][0]}))
                 + n_b * ($signed({6'd0, p[2][1]}) - $signed({6'd0, p[0][1]}))
                 + n_a * ($signed({6'd0, p[2][2]}) - $signed({6'd0, p[0][2]})));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_up_q  <= r_upper[r_c[AW-1:0]];
            r_mid_q <= r_middle[r_c[AW-1:0]];
        end
        if (r_state == S_WRITE) begin
            r_upper[r_c[AW-1:0]]  <= r_mid_q;
            r_middle[r_c[AW-1:0]] <= n_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= gem_pkg::ResetWidth;
            r_height <= gem_pkg::ResetHeight;
            r_op     <= gem_pkg::OpSobel;
            r_col    <= '0;
            r_row    <= '0;
            o_grad   <= '0;
            for (int i = 0; i < 9; i++) r_win[i] <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == gem_pkg::RegWidth || i_cfg_index == gem_pkg::RegHeight) begin
                    if (i_cfg_index == gem_pkg::RegWidth) r_width <= i_cfg_data;
                    else r_height <= i_cfg_data;
                    r_col <= '0;
                    r_row <= '0;
                    for (int i = 0; i < 9; i++) r_win[i] <= '0;
                end else if (i_cfg_index == gem_pkg::RegOp) begin
                    r_op <= i_cfg_data[1:0];
                end
            end
            case (r_state)
                S_IDLE: begin
                    o_grad.valid <= 1'b0;
                    if (i_start && !(i_mode && !n_flush)) begin
                        r_px    <= i_pixel;
                        r_c     <= n_c;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    o_grad.valid <= 1'b0;
                    r_state      <= S_WRITE;
                end
                S_WRITE: begin
                    r_win[0] <= r_win[1]; r_win[1] <= r_win[2]; r_win[2] <= n_t0;
                    r_win[3] <= r_win[4]; r_win[4] <= r_win[5]; r_win[5] <= n_t1;
                    r_win[6] <= r_win[7]; r_win[7] <= r_win[8]; r_win[8] <= n_t2;
                    o_grad.valid <= n_emit;
                    o_grad.last  <= n_last;
                    o_grad.op    <= r_op;
                    o_grad.gx    <= n_gx;
                    o_grad.gy    <= n_gy;
                    if (n_last) begin
                        r_col <= '0;
                        r_row <= '0;
                    end else if (r_c + (AW+1)'(1) >= n_w) begin
                        r_col <= '0;
                        r_row <= r_row + HW'(1);
                    end else begin
                        r_col <= r_c + (AW+1)'(1);
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    o_grad.valid <= 1'b0;
                    r_state      <= S_IDLE;
                end
            endcase
        end
    end
endmodule

/* verif/gradient_edge_magnitude_tb.sv */
// Self-checking testbench for gradient_edge_magnitude: drives pixel and drain
// beats, predicts every edge result internally and compares at the output.
// Depends on gem_pkg and the gradient_edge_magnitude RTL.
`timescale 1ns / 100ps

module gradient_edge_magnitude_tb;

    localparam int LineMax       = 1024;
    localparam int HeightMax     = 1024;
    localparam int WatchdogLimit = 3000;
    // Cycles allowed for a beat that produces no result to finish inside the block.
    localparam int SettleCycles  = 60;
    localparam bit ModePixel     = 1'b0;
    localparam bit ModeDrain     = 1'b1;

    typedef struct {
        logic [7:0] edge_value;
        logic       frame_end;
    } t_edge_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_mode = 1'b0;
    logic [7:0]  i_pixel = 8'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_edge_value;
    logic        o_frame_end;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = gem_pkg::RegWidth;
    logic [10:0] i_cfg_data = 11'd0;

    gradient_edge_magnitude u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_mode(i_mode), .i_pixel(i_pixel),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_edge_value(o_edge_value), .o_frame_end(o_frame_end),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Mirror of the block's state, kept in step with every accepted beat.
    logic [10:0] width_reg, height_reg;
    logic [1:0]  op_reg;
    logic [7:0]  upper_row [LineMax];
    logic [7:0]  middle_row [LineMax];
    logic [7:0]  window [9];
    int          next_col, next_row;

    t_edge_result expected_edges[$];
    int  mismatch_count = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  calm_phase = 1'b0;
    int  beats_sent = 0;

    function automatic int active_width();
        if (width_reg < 1) return 1;
        if (width_reg > LineMax) return LineMax;
        return int'(width_reg);
    endfunction

    function automatic int active_height();
        if (height_reg < 1) return 1;
        if (height_reg > HeightMax) return HeightMax;
        return int'(height_reg);
    endfunction

    function automatic void restart_position();
        next_col = 0;
        next_row = 0;
        for (int i = 0; i < 9; i++) window[i] = 8'd0;
    endfunction

    function automatic int floor_root(longint v);
        longint acc;
        acc = 0;
        for (int k = 15; k >= 0; k--) begin
            if ((acc | (64'd1 << k)) * (acc | (64'd1 << k)) <= v) acc = acc | (64'd1 << k);
        end
        return int'(acc);
    endfunction

    // Magnitude of the gradient over the current window; the fix flags replicate
    // the centre column where the left or right neighbour lies past the border.
    function automatic logic [7:0] window_magnitude(bit left_fix, bit right_fix);
        int p [3][3];
        int gx, gy, side, centre, divisor, mag;
        for (int i = 0; i < 3; i++) begin
            p[i][1] = int'(window[i*3+1]);
            p[i][0] = left_fix ? p[i][1] : int'(window[i*3]);
            p[i][2] = right_fix ? p[i][1] : int'(window[i*3+2]);
        end
        case (op_reg)
            gem_pkg::OpSobel:   begin side = 1; centre = 2;  divisor = 4;  end
            gem_pkg::OpPrewitt: begin side = 1; centre = 1;  divisor = 3;  end
            gem_pkg::OpScharr:  begin side = 3; centre = 10; divisor = 16; end
            default:            begin side = 1; centre = 1;  divisor = 1;  end
        endcase
        if (op_reg == gem_pkg::OpRoberts) begin
            gx = p[1][1] - p[2][2];
            gy = p[2][1] - p[1][2];
        end else begin
            gx = side * (p[0][2] - p[0][0]) + centre * (p[1][2] - p[1][0])
               + side * (p[2][2] - p[2][0]);
            gy = side * (p[2][0] - p[0][0]) + centre * (p[2][1] - p[0][1])
               + side * (p[2][2] - p[0][2]);
        end
        mag = floor_root(longint'(gx) * gx + longint'(gy) * gy) / divisor;
        return (mag > 255) ? 8'd255 : mag[7:0];
    endfunction

    // Advances the mirror by one accepted beat; returns 1 when a result is due.
    function automatic bit edge_predict_step(bit mode, logic [7:0] px,
                                             output t_edge_result res);
        int w, h, c, r;
        bit flushing, emit, last;
        logic [7:0] incoming;
        logic [7:0] trip [3];
        w = active_width();
        h = active_height();
        c = (next_col >= w) ? 0 : next_col;
        r = next_row;
        flushing = (r >= h);
        res = '{8'd0, 1'b0};
        // A drain beat before the frame is complete is simply ignored.
        if (!flushing && mode == ModeDrain) return 1'b0;
        incoming = flushing ? middle_row[c] : px;
        if (r == 0) begin
            trip[0] = incoming; trip[1] = incoming; trip[2] = incoming;
        end else begin
            trip[0] = (r >= 2) ? upper_row[c] : middle_row[c];
            trip[1] = middle_row[c];
            trip[2] = flushing ? middle_row[c] : incoming;
        end
        upper_row[c] = middle_row[c];
        middle_row[c] = incoming;
        for (int i = 0; i < 3; i++) begin
            window[i*3]   = window[i*3+1];
            window[i*3+1] = window[i*3+2];
            window[i*3+2] = trip[i];
        end
        emit = (r >= 2) || (r == 1 && c >= 1);
        last = (r == h + 1) && (c == 0);
        if (emit) res = '{window_magnitude(c == 1 || w == 1, c == 0), last};
        if (last) begin
            next_col = 0;
            next_row = 0;
        end else begin
            c++;
            if (c >= w) begin
                c = 0;
                r++;
            end
            next_col = c;
            next_row = r;
        end
        return emit;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Receiver: after each result beat the stall length is drawn afresh.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Result checker. Sampling at the rising edge sees the values from before
    // the edge, as the block updates its outputs nonblockingly.
    always @(posedge i_clk) begin
        t_edge_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_edges.size() == 0) begin
                report_mismatch("unexpected result beat, edge_value", o_edge_value, -1);
            end else begin
                want = expected_edges.pop_front();
                if (o_edge_value !== want.edge_value)
                    report_mismatch("edge_value", o_edge_value, want.edge_value);
                if (o_frame_end !== want.frame_end)
                    report_mismatch("frame_end", o_frame_end, want.frame_end);
            end
            stall_left = calm_phase ? 0 : $urandom_range(0, 13);
        end
    end

    // Watchdog: counts cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Sends one beat after a random gap and folds it into the prediction on
    // acceptance. A gap of zero keeps valid high straight into the next beat.
    task automatic send_beat(bit mode, logic [7:0] px);
        int gap;
        t_edge_result res;
        beats_sent++;
        // Stretches of back-to-back traffic alternate with randomly gapped ones.
        if (beats_sent % 150 == 0) calm_phase = ~calm_phase;
        gap = calm_phase ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_pixel <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (edge_predict_step(mode, px, res)) expected_edges = {expected_edges, res};
        @(negedge i_clk);
    endtask

    // Waits until every result is in, then lets a beat without a result finish.
    task automatic wait_quiet();
        i_valid <= 1'b0;
        while (expected_edges.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [10:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (index)
            gem_pkg::RegWidth:  begin width_reg = data; restart_position(); end
            gem_pkg::RegHeight: begin height_reg = data; restart_position(); end
            default:            op_reg = data[1:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(logic [10:0] w, logic [10:0] h, logic [1:0] op);
        wait_quiet();
        write_reg(gem_pkg::RegWidth, w);
        write_reg(gem_pkg::RegHeight, h);
        write_reg(gem_pkg::RegOp, 11'(op));
    endtask

    function automatic logic [7:0] random_pixel();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Sends the pixels of one frame, with stray drain beats, then the flush.
    // Flush beats carry random modes, since a pixel during the flush is discarded.
    task automatic send_frame(int stop_after);
        int total;
        total = active_width() * active_height();
        for (int i = 0; i < total && i < stop_after; i++) begin
            if ($urandom_range(0, 11) == 0) send_beat(ModeDrain, random_pixel());
            send_beat(ModePixel, random_pixel());
        end
        if (stop_after < total) return;
        for (int i = 0; i <= active_width(); i++)
            send_beat(1'($urandom_range(0, 1)), random_pixel());
    endtask

    // The reset geometry is 640 wide: results start after 641 pixels.
    task automatic test_reset_geometry();
        for (int i = 0; i < 645; i++) send_beat(ModePixel, random_pixel());
    endtask

    // Each operator on a 2x2 frame with hard contrast, a drain inside the
    // frame and a pixel beat during the flush.
    task automatic test_operators();
        logic [1:0] ops [4];
        ops = '{gem_pkg::OpSobel, gem_pkg::OpPrewitt, gem_pkg::OpScharr, gem_pkg::OpRoberts};
        foreach (ops[k]) begin
            set_frame(11'd2, 11'd2, ops[k]);
            send_beat(ModePixel, 8'd255);
            send_beat(ModeDrain, 8'd0);
            send_beat(ModePixel, 8'd0);
            send_beat(ModePixel, 8'd0);
            send_beat(ModePixel, 8'd255);
            send_beat(ModePixel, 8'hA5);
            send_beat(ModeDrain, 8'd0);
            send_beat(ModeDrain, 8'd0);
        end
    endtask

    // Geometry extremes, including out-of-range values that clamp. The wide
    // frame is cut short once the first results of its second row are out.
    task automatic test_geometry_limits();
        set_frame(11'd1, 11'd1, gem_pkg::OpSobel);
        send_frame(1 << 30);
        set_frame(11'd0, 11'd0, gem_pkg::OpRoberts);
        send_frame(1 << 30);
        set_frame(11'd2047, 11'd2047, gem_pkg::OpScharr);
        for (int i = 0; i < LineMax + 4; i++) send_beat(ModePixel, random_pixel());
    endtask

    // Random small frames with random operators; some frames are cut short
    // by a geometry write, some get an operator change halfway through.
    task automatic test_random_frames();
        int start, w, h, cut;
        start = beats_sent;
        while (beats_sent - start < 200) begin
            if ($urandom_range(0, 3) != 0 || next_row != 0) begin
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                h = $urandom_range(1, 6);
                set_frame(w[10:0], h[10:0], 2'($urandom_range(0, 3)));
            end
            case ($urandom_range(0, 9))
                0: send_frame($urandom_range(0, active_width() * active_height()));
                1: begin
                    cut = $urandom_range(0, active_width() * active_height());
                    send_frame(cut);
                    wait_quiet();
                    write_reg(gem_pkg::RegOp, 11'($urandom_range(0, 3)));
                    for (int i = cut; i < active_width() * active_height(); i++)
                        send_beat(ModePixel, random_pixel());
                    for (int i = 0; i <= active_width(); i++)
                        send_beat(1'($urandom_range(0, 1)), random_pixel());
                end
                default: send_frame(1 << 30);
            endcase
        end
    endtask

    initial begin
        width_reg  = gem_pkg::ResetWidth;
        height_reg = gem_pkg::ResetHeight;
        op_reg     = gem_pkg::OpSobel;
        restart_position();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_geometry();
        test_operators();
        test_geometry_limits();
        test_random_frames();

        wait_quiet();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

/* filelist.f */
hdl/gem_pkg.sv
hdl/gem_sqrt.sv
hdl/gem_window.sv
hdl/gradient_edge_magnitude.sv
verif/gradient_edge_magnitude_tb.sv
